>>> design/mwm_pkg.sv
// Shared types and constants for the mecanum wheel mixer with ramping.
// Used by the register block, the controller, the datapath and the checker.
package mwm_pkg;

    // Wheel lanes: front left, front right, rear left, rear right
    localparam int NUM_WHEELS = 4;
    localparam int NUM_AXES   = 3;
    localparam int WL_FL      = 0;
    localparam int WL_FR      = 1;
    localparam int WL_RL      = 2;
    localparam int WL_RR      = 3;
    localparam int AX_FWD     = 0;
    localparam int AX_LAT     = 1;
    localparam int AX_YAW     = 2;

    // Quotient bits of the rescale division (result never exceeds 127)
    localparam int DIV_STEPS  = 7;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic [7:0] WHEEL_LIMIT = 8'd127;

    // Configuration register map
    localparam int APB_ADDR_W = 4;
    localparam logic [1:0] REG_FORWARD_GAIN  = 2'd0;
    localparam logic [1:0] REG_LATERAL_GAIN  = 2'd1;
    localparam logic [1:0] REG_YAW_GAIN      = 2'd2;
    localparam logic [1:0] REG_RAMP_FRACTION = 2'd3;

    localparam logic [7:0] GAIN_RESET = 8'd16;
    localparam logic [8:0] RAMP_RESET = 9'd64;

    typedef struct packed {
        logic              mode;
        logic              link_up;
        logic signed [7:0] forward_cmd;
        logic signed [7:0] lateral_cmd;
        logic signed [7:0] turn_cmd;
        logic [8:0]        speed_scale;
    } t_drive_in;

    typedef struct packed {
        logic              halt;
        logic signed [7:0] front_left;
        logic signed [7:0] front_right;
        logic signed [7:0] rear_left;
        logic signed [7:0] rear_right;
    } t_wheel_out;

    typedef struct packed {
        logic [7:0] forward_gain;
        logic [7:0] lateral_gain;
        logic [7:0] yaw_gain;
        logic [8:0] ramp_fraction;
    } t_cfg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_MIX,
        ST_MAXC,
        ST_DIV,
        ST_DFIN,
        ST_RMUL,
        ST_RUPD,
        ST_HALT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic clear_ramp;
        logic mul1;
        logic mul2;
        logic mix;
        logic maxc;
        logic div_step;
        logic div_fin;
        logic ramp_mul;
        logic ramp_upd;
        logic load_halt;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic link_was_up;
        logic need_scale;
    } t_dp_sts;

endpackage

>>> design/mwm_regs.sv
// APB configuration registers: axis gains and ramp fraction.
// Depends on mwm_pkg for the register map and reset values.
module mwm_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [mwm_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    output mwm_pkg::t_cfg                      o_cfg
);
    import mwm_pkg::*;

    logic [7:0] r_forward_gain;
    logic [7:0] r_lateral_gain;
    logic [7:0] r_yaw_gain;
    logic [8:0] r_ramp_fraction;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Register writes, word index from paddr[3:2]
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_forward_gain  <= GAIN_RESET;
            r_lateral_gain  <= GAIN_RESET;
            r_yaw_gain      <= GAIN_RESET;
            r_ramp_fraction <= RAMP_RESET;
        end else if (wr_en) begin
            case (paddr[3:2])
                REG_FORWARD_GAIN:  r_forward_gain  <= pwdata[7:0];
                REG_LATERAL_GAIN:  r_lateral_gain  <= pwdata[7:0];
                REG_YAW_GAIN:      r_yaw_gain      <= pwdata[7:0];
                REG_RAMP_FRACTION: r_ramp_fraction <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        case (paddr[3:2])
            REG_FORWARD_GAIN:  prdata = {24'd0, r_forward_gain};
            REG_LATERAL_GAIN:  prdata = {24'd0, r_lateral_gain};
            REG_YAW_GAIN:      prdata = {24'd0, r_yaw_gain};
            REG_RAMP_FRACTION: prdata = {23'd0, r_ramp_fraction};
            default:           prdata = 32'd0;
        endcase
    end

    assign o_cfg.forward_gain  = r_forward_gain;
    assign o_cfg.lateral_gain  = r_lateral_gain;
    assign o_cfg.yaw_gain      = r_yaw_gain;
    assign o_cfg.ramp_fraction = r_ramp_fraction;

endmodule

>>> design/mwm_ctrl.sv
// Sequencer for one drive transaction: scale, mix, rescale, ramp, output, or a halt result.
// Depends on mwm_pkg for the state enum and command/status structs.
module mwm_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  mwm_pkg::t_drive_in   i_in_data,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output mwm_pkg::t_dp_cmd     o_cmd,
    input  mwm_pkg::t_dp_sts     i_sts
);
    import mwm_pkg::*;

    t_state               r_state, n_state;
    logic [DIV_CNT_W-1:0] r_div_cnt, n_div_cnt;
    logic                 r_out_valid, n_out_valid;
    logic                 out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_div_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_div_cnt   <= n_div_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state     = r_state;
        n_div_cnt   = r_div_cnt;
        o_cmd       = '0;
        out_free    = !r_out_valid || i_out_ready;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    if (i_in_data.mode) begin
                        o_cmd.clear_ramp = 1'b1;
                        n_state          = ST_HALT;
                    end else if (!i_in_data.link_up) begin
                        // halt only on the falling edge of the link flag
                        if (i_sts.link_was_up) begin
                            n_state = ST_HALT;
                        end
                    end else begin
                        n_state = ST_MUL1;
                    end
                end
            end
            ST_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = ST_MUL2;
            end
            ST_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = ST_MIX;
            end
            ST_MIX: begin
                o_cmd.mix = 1'b1;
                n_state   = ST_MAXC;
            end
            ST_MAXC: begin
                o_cmd.maxc = 1'b1;
                n_div_cnt  = '0;
                n_state    = i_sts.need_scale ? ST_DIV : ST_RMUL;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_DFIN;
                end else begin
                    n_div_cnt = r_div_cnt + 1'b1;
                end
            end
            ST_DFIN: begin
                o_cmd.div_fin = 1'b1;
                n_state       = ST_RMUL;
            end
            ST_RMUL: begin
                o_cmd.ramp_mul = 1'b1;
                n_state        = ST_RUPD;
            end
            ST_RUPD: begin
                // ramp state and output register update together
                if (out_free) begin
                    o_cmd.ramp_upd = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            ST_HALT: begin
                if (out_free) begin
                    o_cmd.load_halt = 1'b1;
                    n_out_valid     = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

>>> design/mwm_dp.sv
// Datapath: axis scaling, wheel mixing, bit-serial rescale divider, ramp.
// Depends on mwm_pkg for payload, configuration and command/status types.
module mwm_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mwm_pkg::t_drive_in   i_in_data,
    input  mwm_pkg::t_cfg        i_cfg,
    input  mwm_pkg::t_dp_cmd     i_cmd,
    output mwm_pkg::t_dp_sts     o_sts,
    output mwm_pkg::t_wheel_out  o_out_data
);
    import mwm_pkg::*;

    t_drive_in          r_in;
    logic               r_link_was_up;
    logic signed [16:0] r_p1   [NUM_AXES];
    logic signed [25:0] r_p2   [NUM_AXES];
    logic signed [9:0]  r_sum  [NUM_WHEELS];
    logic [8:0]         r_mx;
    logic [8:0]         r_rem  [NUM_WHEELS];
    logic [6:0]         r_dvd  [NUM_WHEELS];
    logic signed [7:0]  r_tgt  [NUM_WHEELS];
    logic signed [18:0] r_rprod[NUM_WHEELS];
    logic signed [7:0]  r_ramp [NUM_WHEELS];
    t_wheel_out         r_out;

    logic signed [7:0]  cmd_ax  [NUM_AXES];
    logic [7:0]         gain_ax [NUM_AXES];
    logic [24:0]        pmag    [NUM_AXES];
    logic [12:0]        pq      [NUM_AXES];
    logic signed [7:0]  ax      [NUM_AXES];
    logic signed [9:0]  fx, lx, yx;
    logic signed [9:0]  mix     [NUM_WHEELS];
    logic [9:0]         sneg    [NUM_WHEELS];
    logic [8:0]         smag    [NUM_WHEELS];
    logic [8:0]         mx;
    logic [15:0]        dvd     [NUM_WHEELS];
    logic [9:0]         shifted [NUM_WHEELS];
    logic               qbit    [NUM_WHEELS];
    logic [7:0]         qext    [NUM_WHEELS];
    logic signed [8:0]  diff    [NUM_WHEELS];
    logic signed [19:0] vsum    [NUM_WHEELS];
    logic [19:0]        vmag    [NUM_WHEELS];
    logic [19:0]        vrnd    [NUM_WHEELS];
    logic [7:0]         rsat    [NUM_WHEELS];
    logic signed [7:0]  ramp_nx [NUM_WHEELS];

    assign cmd_ax[AX_FWD]  = r_in.forward_cmd;
    assign cmd_ax[AX_LAT]  = r_in.lateral_cmd;
    assign cmd_ax[AX_YAW]  = r_in.turn_cmd;
    assign gain_ax[AX_FWD] = i_cfg.forward_gain;
    assign gain_ax[AX_LAT] = i_cfg.lateral_gain;
    assign gain_ax[AX_YAW] = i_cfg.yaw_gain;

    // Axis result: truncate toward zero by 4096, saturate to -128..127
    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            pmag[a] = r_p2[a][25] ? 25'(-r_p2[a]) : r_p2[a][24:0];
            pq[a]   = pmag[a][24:12];
            if (r_p2[a][25]) begin
                ax[a] = (pq[a] > 13'd128) ? 8'sh80 : 8'(-pq[a]);
            end else begin
                ax[a] = (pq[a] > 13'd127) ? 8'sd127 : 8'(pq[a]);
            end
        end
    end

    // Wheel mix
    assign fx = {{2{ax[AX_FWD][7]}}, ax[AX_FWD]};
    assign lx = {{2{ax[AX_LAT][7]}}, ax[AX_LAT]};
    assign yx = {{2{ax[AX_YAW][7]}}, ax[AX_YAW]};
    assign mix[WL_FL] = -fx - yx - lx;
    assign mix[WL_FR] = -fx + yx + lx;
    assign mix[WL_RL] = -fx - yx + lx;
    assign mix[WL_RR] = -fx + yx - lx;

    // Magnitudes, their maximum, and the rescale dividends |sum|*127
    always_comb begin
        mx = '0;
        for (int w = 0; w < NUM_WHEELS; w++) begin
            sneg[w] = -r_sum[w];
            smag[w] = r_sum[w][9] ? sneg[w][8:0] : r_sum[w][8:0];
            if (smag[w] > mx) begin
                mx = smag[w];
            end
            dvd[w] = {smag[w], 7'd0} - {7'd0, smag[w]};
        end
    end

    assign o_sts.need_scale  = (mx > {1'b0, WHEEL_LIMIT});
    assign o_sts.link_was_up = r_link_was_up;

    // Restoring divider step per wheel, quotient shifts into r_dvd
    always_comb begin
        for (int w = 0; w < NUM_WHEELS; w++) begin
            shifted[w] = {r_rem[w], r_dvd[w][6]};
            qbit[w]    = (shifted[w] >= {1'b0, r_mx});
            qext[w]    = {1'b0, r_dvd[w]};
        end
    end

    // Ramp: last*256 + frac*(target-last), round half away from zero
    always_comb begin
        for (int w = 0; w < NUM_WHEELS; w++) begin
            diff[w] = {r_tgt[w][7], r_tgt[w]} - {r_ramp[w][7], r_ramp[w]};
            vsum[w] = $signed({{4{r_ramp[w][7]}}, r_ramp[w], 8'd0})
                    + $signed({r_rprod[w][18], r_rprod[w]});
            vmag[w] = vsum[w][19] ? 20'(-vsum[w]) : vsum[w];
            vrnd[w] = vmag[w] + 20'd128;
            rsat[w] = (vrnd[w][19:8] > {4'd0, WHEEL_LIMIT}) ? WHEEL_LIMIT : vrnd[w][15:8];
            ramp_nx[w] = vsum[w][19] ? -rsat[w] : rsat[w];
        end
    end

    // Link flag history and ramp state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_was_up <= 1'b0;
            for (int w = 0; w < NUM_WHEELS; w++) begin
                r_ramp[w] <= '0;
            end
        end else begin
            if (i_cmd.capture) begin
                r_link_was_up <= i_in_data.link_up;
            end
            for (int w = 0; w < NUM_WHEELS; w++) begin
                if (i_cmd.clear_ramp) begin
                    r_ramp[w] <= '0;
                end else if (i_cmd.ramp_upd) begin
                    r_ramp[w] <= ramp_nx[w];
                end
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in <= i_in_data;
        end
        for (int a = 0; a < NUM_AXES; a++) begin
            if (i_cmd.mul1) begin
                r_p1[a] <= cmd_ax[a] * $signed({1'b0, gain_ax[a]});
            end
            if (i_cmd.mul2) begin
                r_p2[a] <= r_p1[a] * $signed({1'b0, r_in.speed_scale});
            end
        end
        if (i_cmd.maxc) begin
            r_mx <= mx;
        end
        for (int w = 0; w < NUM_WHEELS; w++) begin
            if (i_cmd.mix) begin
                r_sum[w] <= mix[w];
            end
            if (i_cmd.maxc) begin
                r_rem[w] <= dvd[w][15:7];
                r_dvd[w] <= dvd[w][6:0];
                r_tgt[w] <= r_sum[w][7:0];
            end
            if (i_cmd.div_step) begin
                r_rem[w] <= qbit[w] ? 9'(shifted[w] - {1'b0, r_mx}) : shifted[w][8:0];
                r_dvd[w] <= {r_dvd[w][5:0], qbit[w]};
            end
            if (i_cmd.div_fin) begin
                r_tgt[w] <= r_sum[w][9] ? -qext[w] : qext[w];
            end
            if (i_cmd.ramp_mul) begin
                r_rprod[w] <= $signed({1'b0, i_cfg.ramp_fraction}) * diff[w];
            end
        end
        // Output register
        if (i_cmd.load_halt) begin
            r_out.halt        <= 1'b1;
            r_out.front_left  <= '0;
            r_out.front_right <= '0;
            r_out.rear_left   <= '0;
            r_out.rear_right  <= '0;
        end else if (i_cmd.ramp_upd) begin
            r_out.halt        <= 1'b0;
            r_out.front_left  <= ramp_nx[WL_FL];
            r_out.front_right <= ramp_nx[WL_FR];
            r_out.rear_left   <= ramp_nx[WL_RL];
            r_out.rear_right  <= ramp_nx[WL_RR];
        end
    end

    assign o_out_data = r_out;

endmodule

>>> design/mecanum_wheel_mixer_ramp.sv
// Mecanum wheel mixer with normalization and ramping. A drive transaction
// is accepted in idle and its result is loaded into an output register
// after the scale, mix, maximum and ramp states, with the rescale divider
// states between them when the largest wheel sum exceeds 127; the next
// transaction is accepted once the sequencer is back in idle, even while
// that result still waits. The rescale is a one-bit-per-cycle restoring
// divider (seven quotient bits, four wheels in parallel). Stop and
// link-lost transactions go through the halt state, which loads a halt
// result; a link-down transaction with the link already down gives no
// result and leaves the sequencer in idle. A stalled output holds the
// sequencer in its last state until the output register is free. Built
// from mwm_regs, mwm_ctrl and mwm_dp.
module mecanum_wheel_mixer_ramp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  mwm_pkg::t_drive_in                 i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output mwm_pkg::t_wheel_out                o_out_data,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [mwm_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import mwm_pkg::*;

    t_cfg    cfg;
    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    mwm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    mwm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (dp_cmd),
        .i_sts       (dp_sts)
    );

    mwm_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cfg      (cfg),
        .i_cmd      (dp_cmd),
        .o_sts      (dp_sts),
        .o_out_data (o_out_data)
    );

endmodule

>>> design/mwm_checker.sv
// Port-level checks for the mecanum wheel mixer, bound to the top level.
// Depends on mwm_pkg for the payload types.
module mwm_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input mwm_pkg::t_drive_in   i_in_data,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input mwm_pkg::t_wheel_out  o_out_data
);
    import mwm_pkg::*;

    // A stalled result stays valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("result payload changed while stalled");

    // Halt results carry zero wheel commands
    a_halt_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.halt |-> o_out_data.front_left == 8'sd0
        && o_out_data.front_right == 8'sd0 && o_out_data.rear_left == 8'sd0
        && o_out_data.rear_right == 8'sd0)
        else $error("halt result with nonzero wheel command");

    // Wheel commands stay within -127..127
    a_wheel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.front_left != 8'sh80
        && o_out_data.front_right != 8'sh80 && o_out_data.rear_left != 8'sh80
        && o_out_data.rear_right != 8'sh80)
        else $error("wheel command out of range");

    // A stop transaction occupies the block for its halt result
    a_stop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.mode |=> !o_in_ready)
        else $error("input ready right after a stop transaction");

endmodule

bind mecanum_wheel_mixer_ramp mwm_checker u_mwm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
